@@ rtl/core/crx_pkg.sv @@
// crx_pkg: shared constants and controller/datapath interface types for the
// checksummed frame receiver. No dependencies.
package crx_pkg;

  // Largest frame length; body store holds the data bytes after the command
  localparam int MAX_FRAME_LEN = 18;
  localparam int LEN_W         = 5;
  localparam int PAY_DEPTH     = MAX_FRAME_LEN - 1;
  localparam int PAY_AW        = $clog2(PAY_DEPTH);

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HOST_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

  // Register reset values
  localparam logic [7:0]       HOST_START_RST  = 8'h11;
  localparam logic [7:0]       SLAVE_START_RST = 8'h16;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 5'd18;

  // Frame kinds
  localparam logic KIND_HOST  = 1'b0;
  localparam logic KIND_SLAVE = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic sum_clear;   // highest priority
    logic sum_load;    // running sum takes the start byte
    logic sum_add;     // running sum adds the byte
    logic kind_load;
    logic kind;
    logic len_load;
    logic cmd_load;
    logic cnt_clear;
    logic data_store;
    logic rep_clear;
    logic rep_push;    // load output register, advance replay index
  } crx_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_host;
    logic is_slave;
    logic len_too_big;
    logic len_zero;
    logic len_one;
    logic data_done;
    logic sum_ok;
    logic slot_free;
    logic rep_last;
  } crx_stat_t;

endpackage

@@ rtl/core/crx_datapath.sv @@
// crx_datapath: config registers, running checksum, frame length/count,
// command and body store, replay index and output register. Uses crx_pkg.
module crx_datapath import crx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           rx_byte,
  input  crx_cmd_t             cmd,
  output crx_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 frame_kind,
  output logic [7:0]           out_byte,
  output logic [LEN_W-1:0]     byte_index,
  output logic                 last
);

  logic [7:0]       host_start_code;
  logic [7:0]       slave_start_code;
  logic [LEN_W-1:0] max_length;

  logic             kind_seen;
  logic [LEN_W-1:0] declared_length;
  logic [7:0]       running_sum;
  logic [LEN_W-1:0] data_count;
  logic [7:0]       command_held;
  logic [7:0]       payload_store [PAY_DEPTH];
  logic [LEN_W-1:0] rep_idx;

  logic [7:0]       sum_in;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] rd_idx;
  logic [7:0]       rd_byte;

  // Configuration writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      host_start_code  <= HOST_START_RST;
      slave_start_code <= SLAVE_START_RST;
      max_length       <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOST_START:  host_start_code  <= cfg_data;
        REG_SLAVE_START: slave_start_code <= cfg_data;
        REG_MAX_LENGTH:  max_length       <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Status toward the controller
  assign sum_in = running_sum + rx_byte;
  assign limit  = (max_length > LEN_W'(MAX_FRAME_LEN)) ? LEN_W'(MAX_FRAME_LEN) : max_length;

  always_comb begin
    stat.is_host     = (rx_byte == host_start_code);
    stat.is_slave    = (rx_byte == slave_start_code);
    stat.len_too_big = (rx_byte > {{(8-LEN_W){1'b0}}, limit});
    stat.len_zero    = (declared_length == '0);
    stat.len_one     = (declared_length == LEN_W'(1));
    stat.data_done   = (({1'b0, data_count} + (LEN_W+1)'(2)) >= {1'b0, declared_length});
    stat.sum_ok      = (sum_in == 8'h00);
    stat.slot_free   = !out_valid || out_ready;
    stat.rep_last    = (rep_idx == (declared_length - LEN_W'(1)));
  end

  // Frame header and checksum state
  always_ff @(posedge clk) begin
    if (rst) begin
      kind_seen       <= KIND_HOST;
      declared_length <= '0;
      running_sum     <= '0;
      data_count      <= '0;
    end else begin
      if (cmd.sum_clear)    running_sum <= '0;
      else if (cmd.sum_load) running_sum <= rx_byte;
      else if (cmd.sum_add)  running_sum <= sum_in;
      if (cmd.kind_load) kind_seen <= cmd.kind;
      if (cmd.len_load)  declared_length <= rx_byte[LEN_W-1:0];
      if (cmd.cnt_clear)       data_count <= '0;
      else if (cmd.data_store) data_count <= data_count + LEN_W'(1);
    end
  end

  // Command byte and body store
  always_ff @(posedge clk) begin
    if (cmd.cmd_load) command_held <= rx_byte;
    if (cmd.data_store && (data_count < LEN_W'(PAY_DEPTH)))
      payload_store[data_count[PAY_AW-1:0]] <= rx_byte;
  end

  // Replay read: index 0 is the command byte
  assign rd_idx  = rep_idx - LEN_W'(1);
  assign rd_byte = (rep_idx == '0) ? command_held : payload_store[rd_idx[PAY_AW-1:0]];

  // Replay index
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_idx <= '0;
    end else if (cmd.rep_clear) begin
      rep_idx <= '0;
    end else if (cmd.rep_push) begin
      rep_idx <= rep_idx + LEN_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rep_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_push) begin
      frame_kind <= kind_seen;
      out_byte   <= rd_byte;
      byte_index <= rep_idx;
      last       <= stat.rep_last;
    end
  end

endmodule

@@ rtl/core/crx_ctrl.sv @@
// crx_ctrl: frame parse and replay state machine; drives datapath commands
// from datapath status. Uses crx_pkg.
module crx_ctrl import crx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  crx_stat_t stat,
  output crx_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_START,
    ST_LEN,
    ST_CMD,
    ST_DATA,
    ST_CS,
    ST_REPLAY
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign in_ready = (state != ST_REPLAY);
  assign take     = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_START: if (take) begin
        if (stat.is_host || stat.is_slave) begin
          cmd.kind_load = 1'b1;
          cmd.kind      = stat.is_host ? KIND_HOST : KIND_SLAVE;
          cmd.sum_load  = 1'b1;
          state_next    = ST_LEN;
        end else begin
          cmd.sum_clear = 1'b1;
        end
      end
      ST_LEN: if (take) begin
        if (stat.len_too_big) begin
          cmd.sum_clear = 1'b1;
          state_next    = ST_START;
        end else begin
          cmd.len_load = 1'b1;
          cmd.sum_add  = 1'b1;
          state_next   = ST_CMD;
        end
      end
      ST_CMD: if (take) begin
        cmd.cmd_load  = 1'b1;
        cmd.sum_add   = 1'b1;
        cmd.cnt_clear = 1'b1;
        if (stat.len_zero) begin
          cmd.sum_clear = 1'b1;
          state_next    = ST_START;
        end else if (stat.len_one) begin
          state_next = ST_CS;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: if (take) begin
        cmd.data_store = 1'b1;
        cmd.sum_add    = 1'b1;
        if (stat.data_done) state_next = ST_CS;
      end
      ST_CS: if (take) begin
        cmd.sum_clear = 1'b1;
        if (stat.sum_ok) begin
          cmd.rep_clear = 1'b1;
          state_next    = ST_REPLAY;
        end else begin
          state_next = ST_START;
        end
      end
      ST_REPLAY: if (stat.slot_free) begin
        cmd.rep_push = 1'b1;
        if (stat.rep_last) state_next = ST_START;
      end
      default: state_next = ST_START;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/checksummed_frame_receiver.sv @@
// checksummed_frame_receiver: top level; joins crx_ctrl and crx_datapath.
// Uses crx_pkg.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_ready, rx_byte               | in_valid && in_ready
//  out     | out_valid, out_ready, frame_kind,         | out_valid && out_ready
//          | out_byte, byte_index, last                |
//  cfg     | cfg_we, cfg_index, cfg_data               | cfg_we
//
// After the checksum byte of a good frame of length L, in_ready stays low while
// the L body bytes replay, one byte per cycle unless the output stalls, from the
// held command byte and the body store. Reset is synchronous; no clearing pass
// is needed. A result waiting in the output register does not hold off the next
// input byte.
module checksummed_frame_receiver import crx_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 frame_kind,
  output logic [7:0]           out_byte,
  output logic [LEN_W-1:0]     byte_index,
  output logic                 last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  crx_cmd_t  cmd;
  crx_stat_t stat;

  crx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crx_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_kind (frame_kind),
    .out_byte   (out_byte),
    .byte_index (byte_index),
    .last       (last)
  );

`ifndef ASSERT_OFF
  // Taking a non-final body byte is followed at once by the next one
  a_replay_steps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && byte_index == $past(byte_index) + LEN_W'(1)))
    else $error("replay did not advance to the next body byte");

  // Input is held off while a frame body is only partly replayed
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> !in_ready)
    else $error("input accepted during body replay");

  // A body always begins with the command byte
  a_body_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (byte_index == '0))
    else $error("body replay did not start at the command byte");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking testbench for checksummed_frame_receiver; a directed table, then random
// framed traffic over several register settings, checked against a built-in frame predictor.
// Depends on crx_pkg and the checksummed_frame_receiver RTL.
module tb;
  import crx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int ITEMS_PER_PHASE = 48;
  localparam int N_PHASES        = 8;
  localparam int TAIL_CYCLES     = 30;

  typedef enum logic [2:0] {WAIT_START, WAIT_LEN, WAIT_CMD, WAIT_DATA, WAIT_SUM} rx_phase_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] idx;
    logic             fin;
  } body_res_t;

  // Directed rows: RX is checked by the predictor, QUIET expects no result,
  // SOLO expects one typed body byte, CFG is a register write
  typedef enum logic [1:0] {ROW_RX, ROW_QUIET, ROW_SOLO, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] val;   // rx byte, or register index
    logic [7:0] dat;   // register data, or typed out_byte
    logic       knd;
  } dir_row_t;

  dir_row_t dir_rows [26] = '{
    // unknown start bytes at both extremes
    '{ROW_QUIET, 8'h00, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'hFF, 8'h00, KIND_HOST},
    // good host frame of length one
    '{ROW_QUIET, 8'h11, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h01, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'hFF, 8'h00, KIND_HOST},
    '{ROW_SOLO,  8'hEF, 8'hFF, KIND_HOST},
    // zero length: dropped after the command byte
    '{ROW_QUIET, 8'h16, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h00, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h55, 8'h00, KIND_HOST},
    // length above the maximum
    '{ROW_QUIET, 8'h11, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h13, 8'h00, KIND_HOST},
    // bad checksum on a slave frame
    '{ROW_QUIET, 8'h16, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h01, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h00, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h00, 8'h00, KIND_HOST},
    // slave frame with a start code inside its body
    '{ROW_RX,    8'h16, 8'h00, KIND_HOST},
    '{ROW_RX,    8'h02, 8'h00, KIND_HOST},
    '{ROW_RX,    8'h00, 8'h00, KIND_HOST},
    '{ROW_RX,    8'h11, 8'h00, KIND_HOST},
    '{ROW_RX,    8'hD7, 8'h00, KIND_HOST},
    // both start codes equal: host wins
    '{ROW_CFG,   8'(REG_SLAVE_START), 8'h11, KIND_HOST},
    '{ROW_QUIET, 8'h11, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h01, 8'h00, KIND_HOST},
    '{ROW_QUIET, 8'h80, 8'h00, KIND_HOST},
    '{ROW_SOLO,  8'h6E, 8'h80, KIND_HOST},
    // write to an unmapped index is ignored
    '{ROW_CFG,   8'(REG_UNMAPPED), 8'h55, KIND_HOST}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 frame_kind;
  logic [7:0]           out_byte;
  logic [LEN_W-1:0]     byte_index;
  logic                 last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;

  // Predictor state and register copies
  rx_phase_t        ph = WAIT_START;
  logic             kind_q = KIND_HOST;
  logic [LEN_W-1:0] len_q = '0;
  logic [7:0]       sum_q = 8'h00;
  logic [LEN_W-1:0] cnt_q = '0;
  logic [7:0]       cmd_q = 8'h00;
  logic [7:0]       body_q [MAX_FRAME_LEN];
  logic [7:0]       host_code = HOST_START_RST;
  logic [7:0]       slave_code = SLAVE_START_RST;
  logic [LEN_W-1:0] max_len = MAX_LENGTH_RST;

  body_res_t step_res [$];   // body bytes released by the last rx byte
  body_res_t pending  [$];   // body bytes still owed by the DUT
  int        fail_ct = 0;
  bit        calm_in = 1'b0;
  bit        calm_out = 1'b0;
  int        stall_left = 0;
  int        out_cyc = 0;

  checksummed_frame_receiver DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_kind (frame_kind),
    .out_byte   (out_byte),
    .byte_index (byte_index),
    .last       (last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Effective length limit: max_length clamped to the frame store size
  function automatic int len_cap();
    return (int'(max_len) > MAX_FRAME_LEN) ? MAX_FRAME_LEN : int'(max_len);
  endfunction

  // Frame parser: advances on one rx byte, fills step_res on a good checksum
  function automatic void parse_rx(input logic [7:0] b);
    body_res_t r;
    int        i;
    step_res.delete();
    case (ph)
      WAIT_START: begin
        if (b == host_code) begin
          kind_q = KIND_HOST;
          sum_q  = b;
          ph     = WAIT_LEN;
        end else if (b == slave_code) begin
          kind_q = KIND_SLAVE;
          sum_q  = b;
          ph     = WAIT_LEN;
        end else begin
          sum_q = 8'h00;
        end
      end
      WAIT_LEN: begin
        if (int'(b) > len_cap()) begin
          ph    = WAIT_START;
          sum_q = 8'h00;
        end else begin
          len_q = b[LEN_W-1:0];
          sum_q = sum_q + b;
          ph    = WAIT_CMD;
        end
      end
      WAIT_CMD: begin
        cmd_q = b;
        sum_q = sum_q + b;
        cnt_q = '0;
        if (len_q == 0) begin
          ph    = WAIT_START;
          sum_q = 8'h00;
        end else if (len_q == 1) begin
          ph = WAIT_SUM;
        end else begin
          ph = WAIT_DATA;
        end
      end
      WAIT_DATA: begin
        if (int'(cnt_q) < MAX_FRAME_LEN) body_q[cnt_q] = b;
        cnt_q = cnt_q + 1'b1;
        sum_q = sum_q + b;
        if (int'(cnt_q) + 1 >= int'(len_q)) ph = WAIT_SUM;
      end
      WAIT_SUM: begin
        sum_q = sum_q + b;
        if (sum_q == 8'h00) begin
          for (i = 0; i < int'(len_q) && i < MAX_FRAME_LEN; i++) begin
            r.kind = kind_q;
            if (i == 0) r.data = cmd_q;
            else r.data = body_q[i-1];
            r.idx = LEN_W'(i);
            r.fin = (i + 1 == int'(len_q));
            step_res.push_back(r);
          end
        end
        ph    = WAIT_START;
        sum_q = 8'h00;
      end
      default: begin
        ph    = WAIT_START;
        sum_q = 8'h00;
      end
    endcase
  endfunction

  task automatic note_fail(input string msg);
    fail_ct++;
    if (fail_ct <= 10) $display("%s", msg);
  endtask

  // One rx transfer after a random gap; parses it and optionally queues its results
  task automatic push_byte(input logic [7:0] b, input bit keep);
    int r;
    int gap;
    gap = 0;
    if (!calm_in) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(12, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    parse_rx(b);
    if (keep) foreach (step_res[i]) pending.push_back(step_res[i]);
  endtask

  // Wait until every owed body byte has come out and the block has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write, with the enable dropped again afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_HOST_START:  host_code = val;
      REG_SLAVE_START: slave_code = val;
      REG_MAX_LENGTH:  max_len = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // One random frame: mostly well formed, the rest dropped, broken or noise
  task automatic send_frame(output int sent);
    logic [7:0] fb [$];
    logic [7:0] sum;
    logic       kind;
    int         r;
    int         cap;
    int         n;
    cap     = len_cap();
    r       = $urandom_range(0, 99);
    kind    = 1'($urandom_range(0, 1));
    calm_in = ($urandom_range(0, 3) == 0);
    fb.push_back(kind ? slave_code : host_code);
    if (r < 74) begin
      n = ($urandom_range(0, 6) == 0) ? cap : $urandom_range(1, (cap < 5) ? cap : 5);
      fb.push_back(8'(n));
      repeat (n) fb.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (fb[i]) sum = sum + fb[i];
      fb.push_back(~sum + 8'd1);
      // corrupt the checksum now and then
      if ($urandom_range(0, 6) == 0) fb[fb.size()-1] ^= 8'($urandom_range(1, 255));
    end else if (r < 81) begin
      if ($urandom_range(0, 1) == 1) fb.push_back(8'($urandom_range(cap + 1, 31)));
      else fb.push_back(8'($urandom_range(cap + 1, 255)));
    end else if (r < 86) begin
      fb.push_back(8'h00);
      fb.push_back(8'($urandom_range(0, 255)));
    end else if (r < 93) begin
      // truncated frame, the next start byte lands inside it
      n = $urandom_range(1, cap);
      fb.push_back(8'(n));
      repeat ($urandom_range(0, n)) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      fb.delete();
      repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom_range(0, 255)));
    end
    foreach (fb[i]) push_byte(fb[i], 1'b1);
    sent = (r < 93) ? fb.size() : 0;
  endtask

  // Output stalls: short mostly, a few long, with calm stretches
  always @(posedge clk) begin
    out_cyc <= out_cyc + 1;
    if (out_cyc % 256 == 0) calm_out <= ($urandom_range(0, 2) == 0);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Body byte checker
  always @(posedge clk) begin
    body_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        note_fail($sformatf("unexpected transfer: kind=%0d byte=%02h idx=%0d last=%0d",
                            frame_kind, out_byte, byte_index, last));
      end else begin
        e = pending.pop_front();
        if (frame_kind !== e.kind || out_byte !== e.data ||
            byte_index !== e.idx || last !== e.fin)
          note_fail($sformatf({"mismatch: exp kind=%0d byte=%02h idx=%0d last=%0d, ",
                               "got kind=%0d byte=%02h idx=%0d last=%0d"},
                              e.kind, e.data, e.idx, e.fin,
                              frame_kind, out_byte, byte_index, last));
      end
    end
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    body_res_t  solo;
    logic [7:0] h;
    logic [7:0] s;
    logic [4:0] m;
    int         sent;
    int         done;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].val[CFG_IDX_W-1:0], dir_rows[i].dat);
      end else begin
        push_byte(dir_rows[i].val, dir_rows[i].op == ROW_RX);
        if (dir_rows[i].op == ROW_SOLO) begin
          solo.kind = dir_rows[i].knd;
          solo.data = dir_rows[i].dat;
          solo.idx  = '0;
          solo.fin  = 1'b1;
          pending.push_back(solo);
        end
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      h = 8'($urandom_range(0, 255));
      s = ($urandom_range(0, 4) == 0) ? h : 8'($urandom_range(0, 255));
      m = 5'($urandom_range(1, MAX_FRAME_LEN));
      case (p)
        0: begin h = 8'h00; s = 8'hFF; m = 5'd1; end
        1: begin h = 8'hFF; s = 8'h00; m = 5'(MAX_FRAME_LEN); end
        2: m = 5'd31;
        default: ;
      endcase
      write_reg(REG_HOST_START, h);
      write_reg(REG_SLAVE_START, s);
      write_reg(REG_MAX_LENGTH, {3'b000, m});
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        send_frame(sent);
        done += sent;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_ct == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
